@@ hw/rtl/cfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo filter engine package
// Shared payload types, command codes and hash constants.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int KEY_W   = 16;
    localparam int HASH_W  = 16;
    localparam int RELOC_W = 4;
    localparam int BYTE_W  = 8;

    // The djb hash starts from this seed; each step is hash * 33 + byte.
    localparam logic [HASH_W-1:0] HASH_SEED = 16'd5381;
    localparam int HASH_SHIFT = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic PICK_SECOND = 1'b0;
    localparam logic PICK_FIRST  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [KEY_W-1:0]  key;
        logic              evict_pick;
    } request_t;

    typedef struct packed {
        logic               hit_or_stored;
        logic [RELOC_W-1:0] relocations;
    } response_t;

endpackage

@@ hw/rtl/cfe_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo filter engine stream channel
// Valid/ready channel that carries one payload per transfer.
// ----------------------------------------------------------------------------
interface cfe_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ hw/rtl/cfe_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo filter engine hash unit
// Sixteen-bit djb hash of a two-byte value, low byte first.
// ----------------------------------------------------------------------------
module cfe_hash (
    input  logic [cfe_pkg::KEY_W-1:0]  value,
    output logic [cfe_pkg::HASH_W-1:0] hash
);

    logic [cfe_pkg::HASH_W-1:0] low_byte;
    logic [cfe_pkg::HASH_W-1:0] high_byte;
    logic [cfe_pkg::HASH_W-1:0] first_step;

    assign low_byte  = {{(cfe_pkg::HASH_W-cfe_pkg::BYTE_W){1'b0}},
                        value[cfe_pkg::BYTE_W-1:0]};
    assign high_byte = {{(cfe_pkg::HASH_W-cfe_pkg::BYTE_W){1'b0}},
                        value[2*cfe_pkg::BYTE_W-1:cfe_pkg::BYTE_W]};

    // Multiplying by 33 is a shift by five plus the value itself.
    assign first_step = (cfe_pkg::HASH_SEED << cfe_pkg::HASH_SHIFT)
                        + cfe_pkg::HASH_SEED + low_byte;
    assign hash       = (first_step << cfe_pkg::HASH_SHIFT) + first_step + high_byte;

endmodule

@@ hw/rtl/cfe_bucket_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo filter engine bucket memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfe_bucket_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [cfe_pkg::HASH_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [cfe_pkg::HASH_W-1:0] rd_data
);

    logic [cfe_pkg::HASH_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/cuckoo_filter_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo filter engine
// Insert and lookup of 16-bit keys in a cuckoo filter with one-slot buckets.
// ----------------------------------------------------------------------------
// After reset the engine clears its bucket memory, one bucket per cycle, so
// it takes no request until every bucket is cleared. It then handles one
// request at a time: a lookup, or an insert that finds a free bucket, passes
// through ST_HASH2, ST_READ2, ST_EVAL and ST_DONE before the result is
// offered; an evicting insert adds an ST_RHASH and ST_RCHECK pass per
// relocation step, up to RELOCATION_LIMIT + 1 steps. The sequence is set by
// the single hash unit and the single read port of the bucket memory, which
// every probe goes through in turn. The result sits in an output register,
// so a new request can be taken while the previous result still waits for
// its transfer. Fingerprints are the djb hash of the key, bucket indices
// come from hashes masked with BUCKET_COUNT - 1; a bucket holding zero is empty.
// ----------------------------------------------------------------------------
module cuckoo_filter_engine #(
    parameter int BUCKET_COUNT     = 128,
    parameter int RELOCATION_LIMIT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    cfe_stream_if.sink    request,
    cfe_stream_if.source  response
);

    localparam int IDX_W = $clog2(BUCKET_COUNT);
    localparam int CNT_W = $clog2(RELOCATION_LIMIT + 1);
    localparam logic [IDX_W-1:0] IDX_MASK  = IDX_W'(BUCKET_COUNT - 1);
    localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(BUCKET_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(RELOCATION_LIMIT);
    localparam logic [cfe_pkg::HASH_W-1:0] EMPTY = '0;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH2  = 3'd2;
    localparam logic [2:0] ST_READ2  = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_RHASH  = 3'd5;
    localparam logic [2:0] ST_RCHECK = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    // Working registers of the item in flight.
    logic                       cmd_reg, cmd_next;
    logic                       pick_reg, pick_next;
    logic [cfe_pkg::HASH_W-1:0] fp_reg, fp_next;
    logic [IDX_W-1:0]           i1_reg, i1_next;
    logic [IDX_W-1:0]           i2_reg, i2_next;
    logic [cfe_pkg::HASH_W-1:0] b1_reg, b1_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           alt_reg, alt_next;
    logic [cfe_pkg::HASH_W-1:0] carried_reg, carried_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       ok_reg, ok_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    cfe_pkg::response_t   out_data_reg, out_data_next;

    // Shared hash unit and memory ports.
    logic [cfe_pkg::KEY_W-1:0]  hash_in;
    logic [cfe_pkg::HASH_W-1:0] hash_out;
    logic [IDX_W-1:0]           hash_idx;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [cfe_pkg::HASH_W-1:0] wr_data;
    logic [IDX_W-1:0]           rd_addr;
    logic [cfe_pkg::HASH_W-1:0] rd_data;

    logic                 in_xfer;
    logic                 out_free;
    logic [CNT_W+3:0]     count_wide;

    cfe_hash u_hash (
        .value (hash_in),
        .hash  (hash_out)
    );

    cfe_bucket_ram #(
        .DEPTH  (BUCKET_COUNT),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hash_idx       = hash_out[IDX_W-1:0] & IDX_MASK;
    assign request.ready  = (state_reg == ST_IDLE);
    assign in_xfer        = request.valid && request.ready;
    assign out_free       = !out_valid_reg || response.ready;
    assign response.valid   = out_valid_reg;
    assign response.payload = out_data_reg;
    assign count_wide     = {4'b0000, count_reg};

    // The hash unit serves the key, then the fingerprint, then each carried
    // fingerprint during relocation.
    always_comb
    begin
        case (state_reg)
            ST_HASH2: hash_in = fp_reg;
            ST_RHASH: hash_in = carried_reg;
            default:  hash_in = request.payload.key;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        pick_next      = pick_reg;
        fp_next        = fp_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        b1_next        = b1_reg;
        idx_next       = idx_reg;
        alt_next       = alt_reg;
        carried_next   = carried_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !response.ready;
        wr_en          = 1'b0;
        wr_addr        = clr_cnt_reg;
        wr_data        = EMPTY;
        rd_addr        = i1_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = request.payload.command;
                    pick_next  = request.payload.evict_pick;
                    fp_next    = hash_out;
                    i1_next    = hash_idx;
                    count_next = '0;
                    state_next = ST_HASH2;
                end
            end

            ST_HASH2:
            begin
                // Second index from the fingerprint; first bucket is read.
                i2_next    = i1_reg ^ hash_idx;
                rd_addr    = i1_reg;
                state_next = ST_READ2;
            end

            ST_READ2:
            begin
                b1_next    = rd_data;
                rd_addr    = i2_reg;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (cmd_reg == cfe_pkg::CMD_LOOKUP)
                begin
                    ok_next    = (b1_reg == fp_reg) || (rd_data == fp_reg);
                    state_next = ST_DONE;
                end
                else if (b1_reg == EMPTY)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = i1_reg;
                    wr_data    = fp_reg;
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else if (rd_data == EMPTY)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = i2_reg;
                    wr_data    = fp_reg;
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // Both buckets are taken: evict the chosen one.
                    wr_en   = 1'b1;
                    wr_data = fp_reg;
                    if (pick_reg == cfe_pkg::PICK_FIRST)
                    begin
                        wr_addr      = i1_reg;
                        idx_next     = i1_reg;
                        carried_next = b1_reg;
                    end
                    else
                    begin
                        wr_addr      = i2_reg;
                        idx_next     = i2_reg;
                        carried_next = rd_data;
                    end
                    state_next = ST_RHASH;
                end
            end

            ST_RHASH:
            begin
                alt_next   = idx_reg ^ hash_idx;
                rd_addr    = idx_reg ^ hash_idx;
                state_next = ST_RCHECK;
            end

            ST_RCHECK:
            begin
                wr_addr = alt_reg;
                wr_data = carried_reg;
                if (rd_data == EMPTY)
                begin
                    wr_en      = 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else if (count_reg == CNT_LIMIT)
                begin
                    // Still homeless after the last step: drop the fingerprint.
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    wr_en        = 1'b1;
                    count_next   = count_reg + 1'b1;
                    carried_next = rd_data;
                    idx_next     = alt_reg;
                    state_next   = ST_RHASH;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.hit_or_stored = ok_reg;
                    out_data_next.relocations   = count_wide[3:0];
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pick_reg     <= pick_next;
        fp_reg       <= fp_next;
        i1_reg       <= i1_next;
        i2_reg       <= i2_next;
        b1_reg       <= b1_next;
        idx_reg      <= idx_next;
        alt_reg      <= alt_next;
        carried_reg  <= carried_next;
        count_reg    <= count_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

endmodule
